### sv/csid_pkg.sv
package csid_pkg;

  // Default build of the codon store
  localparam int MAX_CODONS_DEF = 256;
  localparam int CODON_BITS_DEF = 32;

  // Fixed field widths of the request and response channels
  localparam int ACT_W   = 2;
  localparam int POS_W   = 8;
  localparam int LEN_W   = 9;
  localparam int WORD_W  = 32;

  // Request actions
  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE    = 2'd0,
    ACT_READ     = 2'd1,
    ACT_INVERT   = 2'd2,
    ACT_DISPLACE = 2'd3
  } act_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ_WAIT,
    ST_GATHER,
    ST_SCATTER,
    ST_RESULT
  } state_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;    // latch the accepted request
    logic store_wr;   // single codon write
    logic store_rd;   // single codon read
    logic take_rd;    // hold the read codon
    logic pass_init;  // reset the walk counters
    logic gather;     // copy the window into the buffer
    logic scatter;    // copy the buffer back in mutated order
    logic emit;       // load the response register
  } cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic req_ok;     // request operands are in range
    act_t action;     // latched action
    logic pass_done;  // current copy pass has finished
    logic out_free;   // response register can take a new value
  } sts_t;

endpackage

### sv/csid_req_if.sv
interface csid_req_if;
  logic                          valid;
  logic                          ready;
  logic [csid_pkg::ACT_W-1:0]    action;
  logic [csid_pkg::POS_W-1:0]    position;
  logic [csid_pkg::LEN_W-1:0]    seg_length;
  logic [csid_pkg::LEN_W-1:0]    shift_by;
  logic [csid_pkg::WORD_W-1:0]   codon_value;

  modport source (
    output valid, action, position, seg_length, shift_by, codon_value,
    input  ready
  );
  modport sink (
    input  valid, action, position, seg_length, shift_by, codon_value,
    output ready
  );
endinterface

### sv/csid_rsp_if.sv
interface csid_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [csid_pkg::WORD_W-1:0]   codon_out;
  logic                          status;

  modport source (
    output valid, codon_out, status,
    input  ready
  );
  modport sink (
    input  valid, codon_out, status,
    output ready
  );
endinterface

### sv/csid_ram.sv
module csid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port; data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/csid_ctrl.sv
module csid_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  csid_pkg::sts_t sts,
  output csid_pkg::cmd_t cmd
);
  import csid_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!sts.req_ok) begin
          state_nxt = ST_RESULT;
        end else begin
          case (sts.action)
            ACT_WRITE:    state_nxt = ST_RESULT;
            ACT_READ:     state_nxt = ST_READ_WAIT;
            ACT_INVERT:   state_nxt = ST_GATHER;
            ACT_DISPLACE: state_nxt = ST_GATHER;
            default:      state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_READ_WAIT: state_nxt = ST_RESULT;
      ST_GATHER: begin
        if (sts.pass_done) state_nxt = ST_SCATTER;
      end
      ST_SCATTER: begin
        if (sts.pass_done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECIDE: begin
        if (sts.req_ok) begin
          case (sts.action)
            ACT_WRITE:    cmd.store_wr  = 1'b1;
            ACT_READ:     cmd.store_rd  = 1'b1;
            ACT_INVERT:   cmd.pass_init = 1'b1;
            ACT_DISPLACE: cmd.pass_init = 1'b1;
            default:      cmd.store_rd  = 1'b0;
          endcase
        end
      end
      ST_READ_WAIT: cmd.take_rd = 1'b1;
      ST_GATHER: begin
        cmd.gather    = 1'b1;
        cmd.pass_init = sts.pass_done;
      end
      ST_SCATTER: cmd.scatter = 1'b1;
      ST_RESULT:  cmd.emit    = sts.out_free;
      default:    cmd         = '0;
    endcase
  end

endmodule

### sv/csid_dpath.sv
module csid_dpath #(
  parameter int MAX_CODONS = csid_pkg::MAX_CODONS_DEF,
  parameter int CODON_BITS = csid_pkg::CODON_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [csid_pkg::LEN_W-1:0]  cfg_wdata,
  // request payload
  input  logic [csid_pkg::ACT_W-1:0]  in_action,
  input  logic [csid_pkg::POS_W-1:0]  in_position,
  input  logic [csid_pkg::LEN_W-1:0]  in_seg_length,
  input  logic [csid_pkg::LEN_W-1:0]  in_shift_by,
  input  logic [csid_pkg::WORD_W-1:0] in_codon_value,
  // response
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [csid_pkg::WORD_W-1:0] out_codon_out,
  output logic                        out_status,
  // sequencer
  input  csid_pkg::cmd_t              cmd,
  output csid_pkg::sts_t              sts
);
  import csid_pkg::*;

  localparam int AW = $clog2(MAX_CODONS);

  logic [LEN_W-1:0]      chrom_len_r;
  act_t                  act_r;
  logic [POS_W-1:0]      pos_r;
  logic [LEN_W-1:0]      len_r;
  logic [LEN_W-1:0]      shift_r;
  logic [CODON_BITS-1:0] value_r;
  logic [CODON_BITS-1:0] rd_hold_r;

  logic [LEN_W-1:0]      cnt_r;
  logic [LEN_W-1:0]      walk_r;
  logic [LEN_W-1:0]      src_r;
  logic [LEN_W-1:0]      dst_r;
  logic                  vld_r;

  logic                  out_valid_r;
  logic [WORD_W-1:0]     codon_out_r;
  logic                  status_r;

  logic                  n_ok;
  logic                  inv_ok;
  logic                  disp_ok;
  logic                  req_ok;
  logic [LEN_W:0]        span;
  logic [LEN_W-1:0]      total;
  logic                  issue;
  logic [LEN_W-1:0]      walk_inc;
  logic [LEN_W-1:0]      walk_nxt;
  logic [LEN_W-1:0]      src_inc;
  logic [LEN_W-1:0]      src_nxt;

  logic                  st_we;
  logic [AW-1:0]         st_waddr;
  logic [CODON_BITS-1:0] st_wdata;
  logic                  st_re;
  logic [AW-1:0]         st_raddr;
  logic [CODON_BITS-1:0] st_rdata;
  logic                  bf_we;
  logic                  bf_re;
  logic [CODON_BITS-1:0] bf_rdata;

  // Chromosome length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chrom_len_r <= '0;
    end else if (cfg_we) begin
      chrom_len_r <= cfg_wdata;
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= act_t'(in_action);
      pos_r   <= in_position;
      len_r   <= in_seg_length;
      shift_r <= in_shift_by;
      value_r <= CODON_BITS'(in_codon_value);
    end
    if (cmd.take_rd) begin
      rd_hold_r <= st_rdata;
    end
  end

  // Operand range checks
  assign span    = {1'b0, len_r} + {1'b0, shift_r};
  assign n_ok    = (chrom_len_r != '0) && (32'(chrom_len_r) <= 32'(MAX_CODONS))
                   && ({1'b0, pos_r} < chrom_len_r);
  assign inv_ok  = (len_r != '0) && (len_r <= chrom_len_r);
  assign disp_ok = (chrom_len_r >= LEN_W'(2)) && (len_r != '0) && (len_r < chrom_len_r)
                   && (shift_r != '0) && (span <= {1'b0, chrom_len_r});

  always_comb begin
    case (act_r)
      ACT_WRITE:    req_ok = n_ok;
      ACT_READ:     req_ok = n_ok;
      ACT_INVERT:   req_ok = n_ok && inv_ok;
      ACT_DISPLACE: req_ok = n_ok && disp_ok;
      default:      req_ok = 1'b0;
    endcase
  end

  // Window size; fits LEN_W bits whenever the request is in range
  assign total = (act_r == ACT_INVERT) ? len_r : span[LEN_W-1:0];

  // Walk over the window: circular store index and buffer source index
  assign issue    = (cmd.gather || cmd.scatter) && (cnt_r != total);
  assign walk_inc = walk_r + LEN_W'(1);
  assign walk_nxt = (walk_inc == chrom_len_r) ? '0 : walk_inc;
  assign src_inc  = src_r + LEN_W'(1);

  always_comb begin
    if (act_r == ACT_INVERT) begin
      src_nxt = src_r - LEN_W'(1);
    end else begin
      src_nxt = (src_inc == total) ? '0 : src_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_init) begin
      cnt_r  <= '0;
      walk_r <= {1'b0, pos_r};
      src_r  <= (act_r == ACT_INVERT) ? (len_r - LEN_W'(1)) : len_r;
    end else if (issue) begin
      cnt_r  <= cnt_r + LEN_W'(1);
      walk_r <= walk_nxt;
      src_r  <= src_nxt;
    end
    // write target follows the read in the next cycle
    dst_r <= cmd.gather ? cnt_r : walk_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= issue && !cmd.pass_init;
    end
  end

  // Store ports
  assign st_we    = cmd.store_wr || (cmd.scatter && vld_r);
  assign st_waddr = cmd.store_wr ? AW'(pos_r) : AW'(dst_r);
  assign st_wdata = cmd.store_wr ? value_r : bf_rdata;
  assign st_re    = cmd.store_rd || (cmd.gather && issue);
  assign st_raddr = cmd.store_rd ? AW'(pos_r) : AW'(walk_r);

  // Buffer ports
  assign bf_we = cmd.gather && vld_r;
  assign bf_re = cmd.scatter && issue;

  csid_ram #(
    .WIDTH (CODON_BITS),
    .DEPTH (MAX_CODONS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  csid_ram #(
    .WIDTH (CODON_BITS),
    .DEPTH (MAX_CODONS)
  ) u_window (
    .clk   (clk),
    .we    (bf_we),
    .waddr (AW'(dst_r)),
    .wdata (st_rdata),
    .re    (bf_re),
    .raddr (AW'(src_r)),
    .rdata (bf_rdata)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      codon_out_r <= (req_ok && act_r == ACT_READ) ? WORD_W'(rd_hold_r) : '0;
      status_r    <= !req_ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_codon_out = codon_out_r;
  assign out_status    = status_r;

  assign sts.req_ok    = req_ok;
  assign sts.action    = act_r;
  assign sts.pass_done = (cnt_r == total) && !vld_r;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

### sv/circular_segment_invert_displace.sv
// Channel  Dir  Payload                                         Handshake
// in_ch    in   action, position, seg_length, shift_by, codon   valid/ready
// out_ch   out  codon_out, status                               valid/ready
// cfg      in   cfg_wdata (chromosome length)                   cfg_we
//
// One request at a time. A write or rejected request steps IDLE, DECIDE,
// RESULT; a read adds READ_WAIT. Invert/displace make one copy pass out and
// one pass back through the single-port-pair store and window buffer, over a
// window of W codons (W = seg_length, or seg_length+shift_by). Synchronous
// active-low reset clears control and the length register; the store is
// undefined until written. The response sits in an output register, so the
// next request is taken while it waits; a request finishing before the old
// response leaves stalls until the output register is free.
module circular_segment_invert_displace #(
  parameter int MAX_CODONS = csid_pkg::MAX_CODONS_DEF,
  parameter int CODON_BITS = csid_pkg::CODON_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  csid_req_if.sink                   in_ch,
  csid_rsp_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [csid_pkg::LEN_W-1:0] cfg_wdata
);
  import csid_pkg::*;

  cmd_t cmd;
  sts_t sts;

  csid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csid_dpath #(
    .MAX_CODONS (MAX_CODONS),
    .CODON_BITS (CODON_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_action      (in_ch.action),
    .in_position    (in_ch.position),
    .in_seg_length  (in_ch.seg_length),
    .in_shift_by    (in_ch.shift_by),
    .in_codon_value (in_ch.codon_value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_codon_out  (out_ch.codon_out),
    .out_status     (out_ch.status),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
